// ===== rtl/core/epm_pkg.sv =====
// ---------------------------------------------------------------------------
// epm_pkg
// shared types and constants for the exact pattern matcher
// ---------------------------------------------------------------------------
package epm_pkg;

    localparam int PatternMax    = 64;
    localparam int PositionBits  = 32;
    localparam int IndexBits     = $clog2(PatternMax);
    localparam int LengthBits    = 7;
    localparam int StartBits     = 32;

    localparam logic KIND_PATTERN = 1'b0;
    localparam logic KIND_TEXT    = 1'b1;

    // classified word passed from front to back
    typedef struct packed {
        logic                 is_text;
        logic [IndexBits-1:0] index;
        logic [7:0]           data;
        logic                 last;
    } epm_op_t;

endpackage

// ===== rtl/core/exact_pattern_matcher.sv =====
// ---------------------------------------------------------------------------
// exact_pattern_matcher
// streaming exact string matcher over a loadable pattern of up to 64 bytes
// ---------------------------------------------------------------------------
// Input channel (in_valid/in_ready): kind 0 writes data_byte into pattern
// cell pattern_index; kind 1 is one text byte, end_of_text marks the last.
// Each text byte gives one result word on the output channel
// (out_valid/out_ready): match_found and the start position of the match,
// zero when no match ends there. Pattern writes give no word.
// Config channel (cfg_valid/cfg_ready) writes pattern_length; always ready.
// Throughput is one word per cycle while no held result stalls the cells:
// all 64 cells compare and shift in parallel. A word passes the front
// queue entry, then the cell update into the result register.
// A two-entry queue parts input from the cells; the result register holds
// while out_ready is low, and the queue absorbs input until it fills.
// Reset clears partial matches, position, queue and length (to 1); the
// pattern store is undefined until written.
// ---------------------------------------------------------------------------
module exact_pattern_matcher
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [5:0]  pattern_index,
    input  logic [7:0]  data_byte,
    input  logic        end_of_text,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        match_found,
    output logic [31:0] match_start,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data
);
    import epm_pkg::*;

    logic            op_valid, op_ready;
    epm_op_t         op;
    logic [6:0]      len_reg;

    // length register
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            len_reg <= 7'd1;
        else if (cfg_valid)
            len_reg <= cfg_data;
    end

    epm_front u_front
    (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .pattern_index(pattern_index), .data_byte(data_byte),
        .end_of_text(end_of_text), .op_valid(op_valid), .op_ready(op_ready),
        .op(op)
    );

    epm_back u_back
    (
        .clk(clk), .rst_n(rst_n), .op_valid(op_valid), .op_ready(op_ready),
        .op(op), .pattern_length(len_reg), .out_valid(out_valid),
        .out_ready(out_ready), .match_found(match_found),
        .match_start(match_start)
    );

    // a missing match reports start zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !match_found |-> match_start == '0)
        else $error("start nonzero without match");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(match_start))
        else $error("result changed under stall");

    // an empty queue always takes input
    assert property (@(posedge clk) disable iff (!rst_n)
        !op_valid |-> in_ready)
        else $error("queue empty but input blocked");

endmodule

// ===== rtl/core/epm_front.sv =====
// ---------------------------------------------------------------------------
// epm_front
// input classifier feeding a two-entry queue towards the match engine
// ---------------------------------------------------------------------------
module epm_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                kind,
    input  logic [5:0]          pattern_index,
    input  logic [7:0]          data_byte,
    input  logic                end_of_text,
    output logic                op_valid,
    input  logic                op_ready,
    output epm_pkg::epm_op_t    op
);
    import epm_pkg::*;

    epm_op_t     q_reg [2];
    logic        rd_ptr_reg, rd_ptr_next;
    logic        wr_ptr_reg, wr_ptr_next;
    logic [1:0]  count_reg, count_next;
    epm_op_t     op_in;
    logic        push, pop;

    // classify incoming word
    always_comb
    begin
        op_in.is_text = (kind == KIND_TEXT);
        op_in.index   = pattern_index[IndexBits-1:0];
        op_in.data    = data_byte;
        op_in.last    = end_of_text & (kind == KIND_TEXT);
    end

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid & in_ready;
    assign op_valid = (count_reg != 2'd0);
    assign pop      = op_valid & op_ready;
    assign op       = q_reg[rd_ptr_reg];

    // queue pointers
    always_comb
    begin
        rd_ptr_next = rd_ptr_reg ^ pop;
        wr_ptr_next = wr_ptr_reg ^ push;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= op_in;
        end
    end

endmodule

// ===== rtl/core/epm_back.sv =====
// ---------------------------------------------------------------------------
// epm_back
// pattern cells with shift-and compare, position counter and result register
// ---------------------------------------------------------------------------
module epm_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                op_valid,
    output logic                op_ready,
    input  epm_pkg::epm_op_t    op,
    input  logic [6:0]          pattern_length,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                match_found,
    output logic [31:0]         match_start
);
    import epm_pkg::*;

    logic [7:0]              pat_reg [PatternMax];
    logic [PatternMax-1:0]   bits_reg, bits_next;
    logic [PositionBits-1:0] pos_reg, pos_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    found_reg, found_next;
    logic [StartBits-1:0]    start_reg, start_next;
    logic [LengthBits-1:0]   len_eff;
    logic [IndexBits-1:0]    top;
    logic                    take, text_take;
    logic [PositionBits-1:0] start_full;

    // clamp length into 1..PatternMax
    always_comb
    begin
        if (pattern_length == '0)
            len_eff = LengthBits'(1);
        else if (pattern_length > LengthBits'(PatternMax))
            len_eff = LengthBits'(PatternMax);
        else
            len_eff = pattern_length;
        top = IndexBits'(len_eff - LengthBits'(1));
    end

    assign op_ready  = !out_valid_reg || out_ready;
    assign take      = op_valid & op_ready;
    assign text_take = take & op.is_text;

    // parallel cell update
    always_comb
    begin
        for (int i = 0; i < PatternMax; i++)
        begin
            bits_next[i] = (i < int'(len_eff)) && (pat_reg[i] == op.data) &&
                           ((i == 0) ? 1'b1 : bits_reg[(i == 0) ? 0 : i - 1]);
        end
        start_full = pos_reg - PositionBits'(top);
        found_next = bits_next[top];
        start_next = found_next ? start_full[StartBits-1:0] : '0;
        pos_next   = op.last ? '0 : pos_reg + PositionBits'(1);
        out_valid_next = text_take ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg      <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (text_take)
            begin
                bits_reg <= op.last ? '0 : bits_next;
                pos_reg  <= pos_next;
            end
        end
    end

    // result payload and pattern store
    always_ff @(posedge clk)
    begin
        if (text_take)
        begin
            found_reg <= found_next;
            start_reg <= start_next;
        end
        if (take && !op.is_text)
        begin
            pat_reg[op.index] <= op.data;
        end
    end

    assign out_valid   = out_valid_reg;
    assign match_found = found_reg;
    assign match_start = start_reg;

endmodule

// ===== test/exact_pattern_matcher_tb.sv =====
// ---------------------------------------------------------------------------
// exact_pattern_matcher_tb
// self-checking bench: pattern loads, text streams and length settings go in
// over valid/ready, every result word is checked against a bit-level
// predictor of the partial-match cells, position counter and length register
// ---------------------------------------------------------------------------
module exact_pattern_matcher_tb;

    import epm_pkg::*;

    typedef struct packed {
        logic        found;
        logic [31:0] start;
    } match_word_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        kind;
    logic [5:0]  pattern_index;
    logic [7:0]  data_byte;
    logic        end_of_text;
    logic        out_valid;
    logic        out_ready;
    logic        match_found;
    logic [31:0] match_start;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [6:0]  cfg_data;

    // predictor state
    logic [7:0]            pattern_copy [PatternMax];
    logic [PatternMax-1:0] cell_bits;
    logic [31:0]           text_pos;
    logic [6:0]            length_reg;

    match_word_t expected_matches [$];
    int          error_count;
    int          words_sent;
    bit          calm;

    exact_pattern_matcher uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .pattern_index (pattern_index),
        .data_byte     (data_byte),
        .end_of_text   (end_of_text),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .match_found   (match_found),
        .match_start   (match_start),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    task automatic report(input string msg);
        begin
            $display("mismatch: %s", msg);
            error_count++;
        end
    endtask

    function automatic int active_length();
        begin
            if (length_reg == 0)
                return 1;
            if (length_reg > PatternMax)
                return PatternMax;
            return length_reg;
        end
    endfunction

    // one text byte through the cells, returns the expected result word
    function automatic match_word_t match_step(input logic [7:0] b, input logic last);
        int          len;
        logic        prev;
        match_word_t w;
        begin
            len = active_length();
            for (int c = PatternMax - 1; c >= 0; c--)
            begin
                prev = (c == 0) ? 1'b1 : cell_bits[c-1];
                cell_bits[c] = (c < len) && prev && (pattern_copy[c] == b);
            end
            w.found = cell_bits[len-1];
            w.start = w.found ? text_pos - 32'(len - 1) : 32'd0;
            text_pos = text_pos + 32'd1;
            if (last)
            begin
                text_pos  = '0;
                cell_bits = '0;
            end
            return w;
        end
    endfunction

    // result checker
    always @(posedge clk)
    begin
        match_word_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_matches.size() == 0)
                report("result word with nothing expected");
            else
            begin
                w = expected_matches.pop_front();
                if (match_found !== w.found)
                    report($sformatf("match_found %b, expected %b", match_found, w.found));
                if (match_start !== w.start)
                    report($sformatf("match_start %0d, expected %0d", match_start, w.start));
            end
        end
    end

    // receiver stalls
    always @(negedge clk)
    begin
        out_ready = calm ? 1'b1 : ($urandom_range(99) >= 37);
    end

    // send one word on the input channel, predict on acceptance
    task automatic send_word(input logic k, input logic [5:0] idx,
                             input logic [7:0] b, input logic last);
        begin
            @(negedge clk);
            if (!calm)
            begin
                while ($urandom_range(99) < 37)
                begin
                    in_valid = 1'b0;
                    @(negedge clk);
                end
            end
            in_valid      = 1'b1;
            kind          = k;
            pattern_index = idx;
            data_byte     = b;
            end_of_text   = last;
            do
                @(posedge clk);
            while (!in_ready);
            words_sent++;
            if (k == KIND_PATTERN)
                pattern_copy[idx] = b;
            else
                expected_matches.push_back(match_step(b, last));
        end
    endtask

    task automatic send_text(input logic [7:0] b, input logic last);
        begin
            send_word(KIND_TEXT, 6'($urandom), b, last);
        end
    endtask

    task automatic send_pattern(input int idx, input logic [7:0] b);
        begin
            send_word(KIND_PATTERN, idx[5:0], b, 1'($urandom_range(1)));
        end
    endtask

    // wait for every result, then let the pipeline settle
    task automatic drain();
        begin
            @(negedge clk);
            in_valid = 1'b0;
            while (expected_matches.size() != 0)
                @(negedge clk);
            repeat (4) @(negedge clk);
        end
    endtask

    task automatic set_length(input logic [6:0] v);
        begin
            drain();
            cfg_valid = 1'b1;
            cfg_data  = v;
            do
                @(posedge clk);
            while (!cfg_ready);
            length_reg = v;
            @(negedge clk);
            cfg_valid = 1'b0;
        end
    endtask

    // fill every cell so no unwritten cell is ever compared
    task automatic test_pattern_load();
        begin
            for (int i = 0; i < PatternMax; i++)
                send_pattern(i, (i == 0) ? 8'h00 : (i == 63) ? 8'hFF : 8'($urandom));
        end
    endtask

    // overlapping matches, end mark, zero and all-ones bytes
    task automatic test_basic_match();
        begin
            set_length(7'd2);
            send_pattern(0, 8'h00);
            send_pattern(1, 8'h00);
            send_text(8'h00, 1'b0);
            send_text(8'h00, 1'b0);
            send_text(8'h00, 1'b0);
            send_text(8'hFF, 1'b0);
            send_text(8'h00, 1'b1);
            send_text(8'h00, 1'b0);
            send_text(8'h00, 1'b1);
            send_pattern(1, 8'hFF);
            send_text(8'h00, 1'b0);
            send_text(8'hFF, 1'b1);
        end
    endtask

    // length one, zero, saturated above the store size, and full size
    task automatic test_length_extremes();
        begin
            set_length(7'd1);
            send_text(pattern_copy[0], 1'b0);
            send_text(8'h5A, 1'b1);
            set_length(7'd0);
            send_text(pattern_copy[0], 1'b0);
            send_text(pattern_copy[0], 1'b1);
            set_length(7'd127);
            for (int i = 0; i < PatternMax; i++)
                send_text(pattern_copy[i], i == PatternMax - 1);
            set_length(7'd64);
            send_text(8'h11, 1'b0);
            for (int i = 0; i < PatternMax; i++)
                send_text(pattern_copy[i], i == PatternMax - 1);
        end
    endtask

    // pattern sets with planted occurrences, noise and mid-text rewrites
    task automatic test_random_text();
        int         len;
        int         n;
        logic [7:0] b;
        begin
            while (words_sent < 1000)
            begin
                calm = (words_sent > 500 && words_sent < 700);
                if ($urandom_range(9) < 3)
                begin
                    case ($urandom_range(9))
                        0: set_length(7'd0);
                        1: set_length(7'd127);
                        2: set_length(7'd64);
                        3: set_length(7'($urandom));
                        default: set_length(7'($urandom_range(6, 1)));
                    endcase
                end
                len = active_length();
                for (int i = 0; i < len; i++)
                    send_pattern(i, ($urandom_range(9) == 0) ? 8'($urandom)
                                    : 8'h41 + 8'($urandom_range(2)));
                n = $urandom_range(40, 10);
                for (int i = 0; i < n && words_sent < 1000; i++)
                begin
                    case ($urandom_range(9))
                        0, 1, 2:
                            for (int j = 0; j < len; j++)
                                send_text(pattern_copy[j], 1'b0);
                        3: send_pattern($urandom_range(63), 8'h41 + 8'($urandom_range(2)));
                        4: send_text(8'($urandom), 1'b0);
                        default:
                        begin
                            b = 8'h41 + 8'($urandom_range(2));
                            send_text(b, $urandom_range(29) == 0);
                        end
                    endcase
                end
                send_text(8'h41 + 8'($urandom_range(2)), 1'($urandom_range(1)));
            end
            calm = 1'b0;
        end
    endtask

    initial
    begin
        in_valid      = 1'b0;
        kind          = KIND_PATTERN;
        pattern_index = '0;
        data_byte     = '0;
        end_of_text   = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = 7'd1;
        out_ready     = 1'b0;
        calm          = 1'b0;
        error_count   = 0;
        words_sent    = 0;
        cell_bits     = '0;
        text_pos      = '0;
        length_reg    = 7'd1;
        for (int i = 0; i < PatternMax; i++)
            pattern_copy[i] = 8'h00;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_pattern_load();
        test_basic_match();
        test_length_extremes();
        test_random_text();

        drain();
        repeat (10) @(negedge clk);
        if (expected_matches.size() != 0)
            report("results still expected at end of run");
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // run limit
    initial
    begin
        #(12 * 400000);
        $display("TB_ERROR");
        $finish;
    end

endmodule
